// ===== hdl/gwpm_pkg.sv =====
// ============================================================================
// gwpm_pkg - shared types and constants for the grid window product search
// Widths of the channel payloads, configuration defaults, direction codes
// and the command/status bundles between controller and datapath.
// ============================================================================
package gwpm_pkg;

    // default geometry
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 65536;
    localparam int DEF_WINDOW      = 4;
    localparam int DEF_VALUE_BITS  = 8;

    // fixed payload widths
    localparam int CFG_W      = 9;
    localparam int CELL_W     = 8;
    localparam int PRODUCT_W  = 32;
    localparam int ROW_OUT_W  = 16;
    localparam int COL_OUT_W  = 8;

    // step counter field wide enough for WINDOW up to 9
    localparam int STEP_W = 3;

    // cells per row after reset
    localparam logic [CFG_W-1:0] COLUMNS_RESET = 9'd20;

    // run directions, also the tie order
    typedef enum logic [1:0] {
        DIR_DOWN_LEFT  = 2'd0,
        DIR_DOWN       = 2'd1,
        DIR_DOWN_RIGHT = 2'd2,
        DIR_RIGHT      = 2'd3
    } dir_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;       // latch the accepted cell
        logic              rd_en;      // read the line stores for rd_dir
        dir_t              rd_dir;
        dir_t              dir;        // direction of the product in work
        logic [STEP_W-1:0] step;       // multiply step / flush step
        logic              mul_en;
        logic              mul_last;   // product complete after this step
        logic              write_dly;  // delayed store write, history shift
        logic              flush_wr;   // row end: store one held cell
        logic              row_adv;    // move to the next row
        logic              emit;       // load result register, clear grid
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] dir_en;      // runs that end at the current cell
        logic       row_end;
        logic       last;
        logic       flush_stop;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== hdl/gwpm_if.sv =====
// ============================================================================
// gwpm_if - valid/ready channels of the grid window product search
// Cell input channel and result output channel, each with source and sink.
// ============================================================================
interface gwpm_cell_if import gwpm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;
    logic              last_cell;

    modport source (output valid, output cell_value, output last_cell, input ready);
    modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

interface gwpm_result_if import gwpm_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [PRODUCT_W-1:0] max_product;
    logic [ROW_OUT_W-1:0] start_row;
    logic [COL_OUT_W-1:0] start_column;
    logic [1:0]           direction;
    logic                 found;

    modport source (output valid, output max_product, output start_row,
                    output start_column, output direction, output found,
                    input ready);
    modport sink   (input valid, input max_product, input start_row,
                    input start_column, input direction, input found,
                    output ready);
endinterface

// ===== hdl/gwpm_ctrl.sv =====
// ============================================================================
// gwpm_ctrl - sequencer of the grid window product search
// Accepts a cell, walks the enabled directions through the shared multiplier
// one operand per cycle, then runs the line store writes, row advance and emit.
// ============================================================================
module gwpm_ctrl import gwpm_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int DEPTH  = WINDOW - 1;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_WRITE = 5'b00100,
        S_FLUSH = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    dir_t               dir_reg, dir_next;
    logic [SLOT_W-1:0]  step_reg, step_next;
    logic [2:0]         pick;
    logic [3:0]         above;

    // lowest enabled direction: {hit, code}
    function automatic logic [2:0] first_dir(input logic [3:0] en);
        logic [2:0] r;
        r = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if (en[i])
            begin
                r = {1'b1, 2'(i)};
            end
        end
        return r;
    endfunction

    // directions after the one in work
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            above[i] = (i > int'(dir_reg));
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        step_next  = step_reg;
        pick       = '0;
        cmd        = '0;
        cmd.dir    = dir_reg;
        cmd.rd_dir = dir_reg;
        cmd.step   = STEP_W'(step_reg);
        in_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    pick     = first_dir(status.dir_en);
                    if (pick[2])
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_dir = dir_t'(pick[1:0]);
                        dir_next   = dir_t'(pick[1:0]);
                        step_next  = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == SLOT_W'(DEPTH - 1))
                begin
                    cmd.mul_last = 1'b1;
                    pick         = first_dir(status.dir_en & above);
                    if (pick[2])
                    begin
                        // next direction's read overlaps the last step
                        cmd.rd_en  = 1'b1;
                        cmd.rd_dir = dir_t'(pick[1:0]);
                        dir_next   = dir_t'(pick[1:0]);
                        step_next  = '0;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    step_next = step_reg + SLOT_W'(1);
                end
            end
            S_WRITE:
            begin
                cmd.write_dly = 1'b1;
                if (status.row_end)
                begin
                    step_next  = '0;
                    state_next = S_FLUSH;
                end
                else if (status.last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.flush_wr = 1'b1;
                if (status.flush_stop)
                begin
                    cmd.row_adv = 1'b1;
                    state_next  = status.last ? S_EMIT : S_IDLE;
                end
                else
                begin
                    step_next = step_reg + SLOT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dir_reg   <= DIR_DOWN_LEFT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            step_reg  <= step_next;
        end
    end

    // one cell in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("cell accepted while another is in work");

    // read data is consumed by the first multiply step
    a_read_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (cmd.mul_en && cmd.step == '0))
        else $error("line store read not followed by first multiply step");

    // write phase follows the last product or an item with no runs
    a_write_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ($past(cmd.mul_last) || $past(cmd.load)))
        else $error("write phase entered out of sequence");

endmodule

// ===== hdl/gwpm_dp.sv =====
// ============================================================================
// gwpm_dp - datapath of the grid window product search
// Line stores for the previous rows, row history, position counters, one
// saturating multiplier, best-run tracking and the result register.
// ============================================================================
module gwpm_dp import gwpm_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int WINDOW      = DEF_WINDOW,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [CELL_W-1:0]    cell_value,
    input  logic                 last_cell,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PRODUCT_W-1:0] max_product,
    output logic [ROW_OUT_W-1:0] start_row,
    output logic [COL_OUT_W-1:0] start_column,
    output logic [1:0]           direction,
    output logic                 found
);

    localparam int DEPTH  = WINDOW - 1;
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int J_W    = $clog2(DEPTH + 1);
    localparam int MUL_W  = PRODUCT_W + VALUE_BITS;

    // configuration and grid position
    logic [CFG_W-1:0]      cols_cfg_reg;
    logic [CNT_W-1:0]      cols;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [SLOT_W-1:0]     slot_reg;

    // current cell and row history
    logic [VALUE_BITS-1:0] value_reg;
    logic                  last_reg;
    logic [VALUE_BITS-1:0] hist_reg [DEPTH];

    // line stores, one per held row
    logic [VALUE_BITS-1:0] mem [DEPTH][MAX_COLUMNS];
    logic [VALUE_BITS-1:0] rd_reg [DEPTH];
    logic [COL_W-1:0]      rd_addr [DEPTH];
    logic                  wr_en;
    logic [COL_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    // multiplier
    logic [SLOT_W-1:0]     k;
    logic [VALUE_BITS-1:0] opnd;
    logic [PRODUCT_W-1:0]  mul_a;
    logic [MUL_W-1:0]      mul_full;
    logic [PRODUCT_W-1:0]  mul_sat;
    logic [PRODUCT_W-1:0]  p_reg;

    // best run
    logic                  cand_valid_reg;
    dir_t                  cand_dir_reg;
    logic [ROW_W-1:0]      cand_row;
    logic [COL_W-1:0]      cand_col;
    logic                  take;
    logic [PRODUCT_W-1:0]  best_prod_reg;
    logic [ROW_W-1:0]      best_row_reg;
    logic [COL_W-1:0]      best_col_reg;
    dir_t                  best_dir_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [PRODUCT_W-1:0]  out_prod_reg;
    logic [ROW_OUT_W-1:0]  out_row_reg;
    logic [COL_OUT_W-1:0]  out_col_reg;
    dir_t                  out_dir_reg;
    logic                  out_found_reg;

    // position flags
    logic                  vert_ok;
    logic                  left_ok;
    logic                  dl_ok;
    logic                  row_end;
    logic [COL_W-1:0]      col_left;
    logic [COL_W-1:0]      col_right;
    logic [ROW_W-1:0]      row_up;

    assign k = cmd.step[SLOT_W-1:0];

    // effective row width: zero acts as one, clamp at the store width
    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            cols = CNT_W'(1);
        end
        else if (32'(cols_cfg_reg) > 32'(MAX_COLUMNS))
        begin
            cols = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = CNT_W'(cols_cfg_reg);
        end
    end

    // which runs end at the current cell
    assign vert_ok   = 32'(row_reg) >= 32'(DEPTH);
    assign left_ok   = 32'(col_reg) >= 32'(DEPTH);
    assign dl_ok     = (32'(col_reg) + 32'(DEPTH)) < 32'(cols);
    assign row_end   = (CNT_W'(col_reg) + CNT_W'(1)) >= cols;
    assign col_left  = COL_W'(32'(col_reg) - 32'(DEPTH));
    assign col_right = COL_W'(32'(col_reg) + 32'(DEPTH));
    assign row_up    = ROW_W'(32'(row_reg) - 32'(DEPTH));

    always_comb
    begin
        status                         = '0;
        status.dir_en[DIR_DOWN_LEFT]   = vert_ok && dl_ok;
        status.dir_en[DIR_DOWN]        = vert_ok;
        status.dir_en[DIR_DOWN_RIGHT]  = vert_ok && left_ok;
        status.dir_en[DIR_RIGHT]       = left_ok;
        status.row_end                 = row_end;
        status.last                    = last_reg;
        status.flush_stop              = (k == SLOT_W'(DEPTH - 1)) ||
                                         (32'(k) == 32'(col_reg));
        status.out_free                = !out_valid_reg || out_ready;
    end

    // read address per store: store s holds the row j rows up
    always_comb
    begin
        logic [J_W-1:0] j;
        for (int s = 0; s < DEPTH; s++)
        begin
            if (32'(slot_reg) > 32'(s))
            begin
                j = J_W'(32'(slot_reg) - 32'(s));
            end
            else
            begin
                j = J_W'(32'(slot_reg) + 32'(DEPTH) - 32'(s));
            end
            case (cmd.rd_dir)
                DIR_DOWN_LEFT:  rd_addr[s] = COL_W'(32'(col_reg) + 32'(j));
                DIR_DOWN_RIGHT: rd_addr[s] = COL_W'(32'(col_reg) - 32'(j));
                default:        rd_addr[s] = col_reg;
            endcase
        end
    end

    // store writes: delayed write of the oldest held cell, or row-end flush
    assign wr_en   = (cmd.write_dly && left_ok) || cmd.flush_wr;
    assign wr_addr = cmd.flush_wr ? COL_W'(32'(col_reg) - 32'(k)) : col_left;
    assign wr_data = cmd.flush_wr ? hist_reg[k] : hist_reg[DEPTH-1];

    // saturating multiply, first step starts from the cell itself
    assign opnd     = (cmd.dir == DIR_RIGHT) ? hist_reg[k] : rd_reg[k];
    assign mul_a    = (k == '0) ? PRODUCT_W'(value_reg) : p_reg;
    assign mul_full = MUL_W'(mul_a) * MUL_W'(opnd);
    assign mul_sat  = (mul_full[MUL_W-1:PRODUCT_W] != '0) ? '1
                                                          : mul_full[PRODUCT_W-1:0];

    // start cell of the finished run
    always_comb
    begin
        case (cand_dir_reg)
            DIR_DOWN_LEFT:
            begin
                cand_row = row_up;
                cand_col = col_right;
            end
            DIR_DOWN:
            begin
                cand_row = row_up;
                cand_col = col_reg;
            end
            DIR_DOWN_RIGHT:
            begin
                cand_row = row_up;
                cand_col = col_left;
            end
            default:
            begin
                cand_row = row_reg;
                cand_col = col_left;
            end
        endcase
    end

    // greater product wins; ties go to the earlier start, then lower direction
    always_comb
    begin
        take = 1'b0;
        if (cand_valid_reg)
        begin
            if (p_reg > best_prod_reg)
            begin
                take = 1'b1;
            end
            else if (p_reg == best_prod_reg && p_reg != '0)
            begin
                take = (cand_row < best_row_reg) ||
                       (cand_row == best_row_reg &&
                        (cand_col < best_col_reg ||
                         (cand_col == best_col_reg && cand_dir_reg < best_dir_reg)));
            end
        end
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && !out_ready);

    // control and grid state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg   <= COLUMNS_RESET;
            out_valid_reg  <= 1'b0;
            cand_valid_reg <= 1'b0;
            cand_dir_reg   <= DIR_DOWN_LEFT;
            col_reg        <= '0;
            row_reg        <= '0;
            slot_reg       <= '0;
            best_prod_reg  <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            best_dir_reg   <= DIR_DOWN_LEFT;
            for (int i = 0; i < DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cols_cfg_reg <= cfg_data;
            end
            out_valid_reg  <= out_valid_next;
            cand_valid_reg <= cmd.mul_last;
            cand_dir_reg   <= cmd.dir;

            if (cmd.emit)
            begin
                // result taken: start a fresh grid
                col_reg       <= '0;
                row_reg       <= '0;
                slot_reg      <= '0;
                best_prod_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
                best_dir_reg  <= DIR_DOWN_LEFT;
                for (int i = 0; i < DEPTH; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else
            begin
                if (take)
                begin
                    best_prod_reg <= p_reg;
                    best_row_reg  <= cand_row;
                    best_col_reg  <= cand_col;
                    best_dir_reg  <= cand_dir_reg;
                end
                if (cmd.write_dly)
                begin
                    for (int i = DEPTH - 1; i > 0; i--)
                    begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                    hist_reg[0] <= value_reg;
                    if (!row_end)
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                if (cmd.row_adv)
                begin
                    col_reg  <= '0;
                    row_reg  <= (32'(row_reg) == 32'(MAX_ROWS - 1)) ? '0
                                                                  : row_reg + ROW_W'(1);
                    slot_reg <= (32'(slot_reg) == 32'(DEPTH - 1)) ? '0
                                                                  : slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    // payload registers and line stores
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= VALUE_BITS'(cell_value);
            last_reg  <= last_cell;
        end
        if (cmd.mul_en)
        begin
            p_reg <= mul_sat;
        end
        for (int s = 0; s < DEPTH; s++)
        begin
            if (wr_en && 32'(slot_reg) == 32'(s))
            begin
                mem[s][wr_addr] <= wr_data;
            end
            if (cmd.rd_en)
            begin
                rd_reg[s] <= mem[s][rd_addr[s]];
            end
        end
        if (cmd.emit)
        begin
            out_prod_reg  <= best_prod_reg;
            out_row_reg   <= ROW_OUT_W'(best_row_reg);
            out_col_reg   <= COL_OUT_W'(best_col_reg);
            out_dir_reg   <= best_dir_reg;
            out_found_reg <= (best_prod_reg != '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign max_product  = out_prod_reg;
    assign start_row    = out_row_reg;
    assign start_column = out_col_reg;
    assign direction    = out_dir_reg;
    assign found        = out_found_reg;

    // result register loads only on an emit
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("result valid without emit");

    // every product has been compared before the result is captured
    a_no_pending_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !cand_valid_reg)
        else $error("emit with a product still pending");

    // a new grid starts at the origin with no best run
    a_grid_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (col_reg == '0 && row_reg == '0 && best_prod_reg == '0))
        else $error("grid state not cleared after result");

endmodule

// ===== hdl/grid_window_product_max.sv =====
// ============================================================================
// grid_window_product_max - greatest product of a run of WINDOW grid cells
// Streams a grid in raster order and reports the best run on the last cell.
// ============================================================================
// Usage:
//   cell_in carries one grid cell per beat (cell_value, last_cell) in raster
//   order; cfg_we/cfg_data set the cells per row (reset value 20), written
//   while no cell is in work. result_out carries one beat per grid, on the
//   cell flagged last_cell: max_product, start_row, start_column, direction
//   and found.
//   All products of a cell go through one saturating multiplier, one operand
//   a cycle, for each of the runs (0 to 4) that end at it; a cell is taken only
//   once the previous one's products and store writes are done. The last cell
//   of a row adds a line store write-back of up to WINDOW-1 held cells, one
//   store write a cycle. The result beat is registered: it is loaded in the
//   emit state once the output register is free.
//   Reset clears position, row history and best run; line store contents are
//   never cleared and are only read where already written for this grid.
//   A stalled result is held in its output register; cells keep being taken
//   until the next grid's last cell finds that register still occupied.
// ============================================================================
module grid_window_product_max import gwpm_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int WINDOW      = DEF_WINDOW,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_data,
    gwpm_cell_if.sink          cell_in,
    gwpm_result_if.source      result_out
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    assign cell_in.ready = in_ready;

    // sequencer
    gwpm_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // stores, multiplier and best-run tracking
    gwpm_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .WINDOW      (WINDOW),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cell_value   (cell_in.cell_value),
        .last_cell    (cell_in.last_cell),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (result_out.valid),
        .out_ready    (result_out.ready),
        .max_product  (result_out.max_product),
        .start_row    (result_out.start_row),
        .start_column (result_out.start_column),
        .direction    (result_out.direction),
        .found        (result_out.found)
    );

endmodule
